// File: hw/rtl/psof_pkg.sv
// Shared types, constants and helper functions for the packet statistics
// and passive OS fingerprint block. No dependencies.
`timescale 1ns / 1ps

package psof_pkg;

    localparam int COUNT_WIDTH      = 32;
    localparam int TTL_BINS         = 256;
    localparam int WINDOW_BINS      = 65536;
    localparam int MAX_PACKET_BYTES = 65535;
    localparam int PROFILE_COUNT    = 14;
    localparam int REPORT_ITEMS     = 13;
    localparam int NUM_COUNTERS     = 9;

    localparam int TTL_AW  = $clog2(TTL_BINS);
    localparam int WIN_AW  = $clog2(WINDOW_BINS);
    localparam int PROF_AW = $clog2(PROFILE_COUNT);

    localparam logic [15:0] MAX_POS = 16'(MAX_PACKET_BYTES);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Report item indexes
    localparam logic [3:0] IDX_TOTAL   = 4'd0;
    localparam logic [3:0] IDX_TCP     = 4'd1;
    localparam logic [3:0] IDX_UDP     = 4'd2;
    localparam logic [3:0] IDX_ICMP    = 4'd3;
    localparam logic [3:0] IDX_SYN     = 4'd4;
    localparam logic [3:0] IDX_ACK     = 4'd5;
    localparam logic [3:0] IDX_RST     = 4'd6;
    localparam logic [3:0] IDX_FIN     = 4'd7;
    localparam logic [3:0] IDX_PSH     = 4'd8;
    localparam logic [3:0] IDX_TTL     = 4'd9;
    localparam logic [3:0] IDX_WINDOW  = 4'd10;
    localparam logic [3:0] IDX_PROFILE = 4'd11;
    localparam logic [3:0] IDX_SCORE   = 4'd12;

    // IP protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [3:0] IP_VERSION = 4'd4;

    localparam logic [7:0] SCORE_STEP = 8'd50;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_SCAN_T,
        ST_DRAIN_T,
        ST_SCAN_W,
        ST_DRAIN_W,
        ST_PROF,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [7:0]  ttl_min;
        logic [7:0]  ttl_max;
        logic [15:0] win_min;
        logic [15:0] win_max;
    } t_profile;

    function automatic t_profile profile_rom(input logic [PROF_AW-1:0] idx);
        t_profile p;
        case (idx)
            4'd0:    p = '{8'd128, 8'd128, 16'd65535, 16'd65535};
            4'd1:    p = '{8'd128, 8'd128, 16'd8192,  16'd65535};
            4'd2:    p = '{8'd128, 8'd128, 16'd65535, 16'd65535};
            4'd3:    p = '{8'd64,  8'd64,  16'd65535, 16'd65535};
            4'd4:    p = '{8'd64,  8'd64,  16'd5840,  16'd5840};
            4'd5:    p = '{8'd64,  8'd64,  16'd29200, 16'd29200};
            4'd6:    p = '{8'd64,  8'd64,  16'd28960, 16'd28960};
            4'd7:    p = '{8'd64,  8'd64,  16'd65535, 16'd65535};
            4'd8:    p = '{8'd64,  8'd64,  16'd65535, 16'd65535};
            4'd9:    p = '{8'd255, 8'd255, 16'd8760,  16'd8760};
            4'd10:   p = '{8'd255, 8'd255, 16'd16384, 16'd16384};
            4'd11:   p = '{8'd64,  8'd64,  16'd5840,  16'd65535};
            4'd12:   p = '{8'd64,  8'd64,  16'd65535, 16'd65535};
            4'd13:   p = '{8'd64,  8'd64,  16'd16384, 16'd16384};
            default: p = '{8'd0,   8'd0,   16'd0,     16'd0};
        endcase
        return p;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

endpackage

// File: hw/rtl/packet_stats_os_fingerprint.sv
// Top level of the packet statistics and passive OS fingerprint block.
// Depends on psof_pkg; holds the sequencer, the counters and both histograms.
`timescale 1ns / 1ps

// How to use this block:
// The slave channel carries one beat per packet byte. tuser = 0 marks a packet
// byte in tdata, and tlast marks the final byte of the packet. tuser = 1 is a
// report request; its tdata and tlast are ignored.
// Packet bytes are taken back to back while idle. The final byte of a packet
// leads to the update read state and, for a valid full TCP packet, the update
// write state; together they do a read-modify-write of both histogram memories
// through their single ports. A report sweeps both histograms through one
// shared compare unit, one bin a cycle, TTL then window, each sweep followed
// by a drain state, then scores the 14 profile table entries, then sends 13
// master beats. tdata holds report_index in bits 3:0 and report_value in bits
// 35:4; tlast marks the score beat, the final one of a report. The master beat
// sits in an output register; a stalled receiver holds it and the sequencer
// waits, so no beat is lost or repeated. The slave side is not ready during a
// histogram update, or a report until its final beat is loaded. After reset
// the block sweeps both histograms to zero, one bin a cycle, and takes no slave
// beat until the sweep is done. Counters and bins saturate at their maximum.
module packet_stats_os_fingerprint (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] mode
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [3:0] report_index, [35:4] report_value
    output logic        m_axis_tlast    // report_last
);
    import psof_pkg::*;

    t_state r_state, n_state;

    // Per-packet capture registers
    logic [15:0] r_pos;
    logic [7:0]  r_vl, r_ttl, r_proto, r_flags;
    logic [15:0] r_win;

    logic [COUNT_WIDTH-1:0] r_cnt [NUM_COUNTERS];

    // Histogram memories with registered read data
    logic [COUNT_WIDTH-1:0] ttl_mem [TTL_BINS];
    logic [COUNT_WIDTH-1:0] win_mem [WINDOW_BINS];
    logic [COUNT_WIDTH-1:0] r_ttl_rd, r_win_rd;

    // Shared sweep address and compare pipeline
    logic [WIN_AW-1:0]      r_addr;
    logic [WIN_AW-1:0]      r_scan_a;
    logic                   r_scan_v;
    logic [COUNT_WIDTH-1:0] r_best_cnt;
    logic [TTL_AW-1:0]      r_top_ttl;
    logic [WIN_AW-1:0]      r_top_win;
    logic [PROF_AW-1:0]     r_pidx;
    logic [3:0]             r_best_prof;
    logic [7:0]             r_top_score;
    logic [3:0]             r_emit_idx;

    logic                   r_out_valid, r_out_last;
    logic [3:0]             r_out_idx;
    logic [31:0]            r_out_val;

    logic s_acc, byte_acc, rpt_acc, emit_load;
    logic mem_clear, upd_rd, upd_wr;

    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign byte_acc = s_acc && !s_axis_tuser;
    assign rpt_acc  = s_acc && s_axis_tuser;
    assign emit_load = (r_state == ST_EMIT) && (!r_out_valid || m_axis_tready);

    // Packet byte capture
    logic [7:0]  n_vl;
    logic [5:0]  hl_now;
    logic [15:0] hl_off;
    logic        pos_ok;
    always_comb begin
        pos_ok = (r_pos < MAX_POS);
        n_vl   = (r_pos == 16'd0) ? s_axis_tdata : r_vl;
        hl_now = {n_vl[3:0], 2'b00};
        hl_off = {10'd0, hl_now};
    end

    // End-of-packet checks on captured registers
    logic [5:0]  hl_fin;
    logic        pkt_ok, tcp_full, is_udp, is_icmp, syn, ack;
    always_comb begin
        hl_fin   = {r_vl[3:0], 2'b00};
        pkt_ok   = (r_vl[7:4] == IP_VERSION) && ({10'd0, hl_fin} <= r_pos);
        tcp_full = (r_proto == PROTO_TCP) && ({11'd0, hl_fin} + 17'd20 <= {1'b0, r_pos});
        is_udp   = (r_proto == PROTO_UDP);
        is_icmp  = (r_proto == PROTO_ICMP);
        syn      = r_flags[1];
        ack      = r_flags[4];
    end

    // Shared compare unit
    logic [COUNT_WIDTH-1:0] scan_data;
    logic                   scan_hit;
    always_comb begin
        scan_data = (r_state == ST_SCAN_T || r_state == ST_DRAIN_T) ?
                    r_ttl_rd : r_win_rd;
        scan_hit  = r_scan_v && (scan_data > r_best_cnt);
    end

    // Profile scoring
    t_profile prof;
    logic [7:0] score;
    always_comb begin
        prof  = profile_rom(r_pidx);
        score = 8'd0;
        if ({8'd0, r_top_ttl} >= {8'd0, prof.ttl_min} &&
            {8'd0, r_top_ttl} <= {8'd0, prof.ttl_max})
            score = score + SCORE_STEP;
        if (r_top_win >= prof.win_min && r_top_win <= prof.win_max)
            score = score + SCORE_STEP;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:   if (r_addr == WIN_AW'(WINDOW_BINS - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (rpt_acc) n_state = ST_SCAN_T;
                else if (byte_acc && s_axis_tlast) n_state = ST_UPD_RD;
            end
            ST_UPD_RD:  n_state = (pkt_ok && tcp_full) ? ST_UPD_WR : ST_IDLE;
            ST_UPD_WR:  n_state = ST_IDLE;
            ST_SCAN_T:  if (r_addr == WIN_AW'(TTL_BINS - 1)) n_state = ST_DRAIN_T;
            ST_DRAIN_T: n_state = ST_SCAN_W;
            ST_SCAN_W:  if (r_addr == WIN_AW'(WINDOW_BINS - 1)) n_state = ST_DRAIN_W;
            ST_DRAIN_W: n_state = ST_PROF;
            ST_PROF:    if (r_pidx == PROF_AW'(PROFILE_COUNT - 1)) n_state = ST_EMIT;
            ST_EMIT:    if (emit_load && r_emit_idx == IDX_SCORE) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer
    always_comb begin
        s_axis_tready = 1'b0;
        mem_clear     = 1'b0;
        upd_rd        = 1'b0;
        upd_wr        = 1'b0;
        case (r_state)
            ST_CLEAR:  mem_clear = 1'b1;
            ST_IDLE:   s_axis_tready = 1'b1;
            ST_UPD_RD: upd_rd = pkt_ok && tcp_full;
            ST_UPD_WR: upd_wr = 1'b1;
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_CLEAR;
        else          r_state <= n_state;
    end

    // Histogram memories: clearing sweep, update read and write, and sweep reads
    always_ff @(posedge i_clk) begin
        if (mem_clear) begin
            ttl_mem[r_addr[TTL_AW-1:0]] <= '0;
            win_mem[r_addr]             <= '0;
        end else if (upd_wr) begin
            ttl_mem[r_ttl] <= sat_inc(r_ttl_rd);
            win_mem[r_win] <= sat_inc(r_win_rd);
        end
        if (upd_rd) begin
            r_ttl_rd <= ttl_mem[r_ttl];
            r_win_rd <= win_mem[r_win];
        end else begin
            r_ttl_rd <= ttl_mem[r_addr[TTL_AW-1:0]];
            r_win_rd <= win_mem[r_addr];
        end
    end

    // Packet capture and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_vl    <= '0;
            r_ttl   <= '0;
            r_proto <= '0;
            r_flags <= '0;
            r_win   <= '0;
            for (int i = 0; i < NUM_COUNTERS; i++) r_cnt[i] <= '0;
        end else begin
            if (byte_acc && pos_ok) begin
                r_vl <= n_vl;
                if (r_pos == 16'd8) r_ttl <= s_axis_tdata;
                if (r_pos == 16'd9) r_proto <= s_axis_tdata;
                if (r_pos == hl_off + 16'd13) r_flags <= s_axis_tdata;
                if (r_pos == hl_off + 16'd14) r_win[15:8] <= s_axis_tdata;
                if (r_pos == hl_off + 16'd15) r_win[7:0] <= s_axis_tdata;
                r_pos <= r_pos + 16'd1;
            end
            if (r_state == ST_UPD_RD && pkt_ok) begin
                if (tcp_full) begin
                    r_cnt[IDX_TOTAL] <= sat_inc(r_cnt[IDX_TOTAL]);
                    r_cnt[IDX_TCP]   <= sat_inc(r_cnt[IDX_TCP]);
                    if (syn && !ack) r_cnt[IDX_SYN] <= sat_inc(r_cnt[IDX_SYN]);
                    if (ack && !syn) r_cnt[IDX_ACK] <= sat_inc(r_cnt[IDX_ACK]);
                    if (r_flags[2]) r_cnt[IDX_RST] <= sat_inc(r_cnt[IDX_RST]);
                    if (r_flags[0]) r_cnt[IDX_FIN] <= sat_inc(r_cnt[IDX_FIN]);
                    if (r_flags[3]) r_cnt[IDX_PSH] <= sat_inc(r_cnt[IDX_PSH]);
                end else if (is_udp) begin
                    r_cnt[IDX_TOTAL] <= sat_inc(r_cnt[IDX_TOTAL]);
                    r_cnt[IDX_UDP]   <= sat_inc(r_cnt[IDX_UDP]);
                end else if (is_icmp) begin
                    r_cnt[IDX_TOTAL] <= sat_inc(r_cnt[IDX_TOTAL]);
                    r_cnt[IDX_ICMP]  <= sat_inc(r_cnt[IDX_ICMP]);
                end
            end
            // The packet registers return to zero once the packet is closed.
            if ((r_state == ST_UPD_RD && !(pkt_ok && tcp_full)) || r_state == ST_UPD_WR) begin
                r_pos   <= '0;
                r_vl    <= '0;
                r_ttl   <= '0;
                r_proto <= '0;
                r_flags <= '0;
                r_win   <= '0;
            end
        end
    end

    // Sweep address, compare pipeline, scoring and beat selection
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr       <= '0;
            r_scan_v     <= 1'b0;
            r_scan_a     <= '0;
            r_best_cnt   <= '0;
            r_top_ttl    <= '0;
            r_top_win    <= '0;
            r_pidx       <= '0;
            r_best_prof  <= '0;
            r_top_score  <= '0;
            r_emit_idx   <= '0;
        end else begin
            r_scan_v <= (r_state == ST_SCAN_T) || (r_state == ST_SCAN_W);
            r_scan_a <= r_addr;
            case (r_state)
                ST_CLEAR: r_addr <= r_addr + 1'b1;
                ST_IDLE: begin
                    r_addr       <= '0;
                    r_best_cnt   <= '0;
                    r_top_ttl    <= '0;
                    r_top_win    <= '0;
                    r_pidx       <= '0;
                    r_best_prof  <= '0;
                    r_top_score  <= '0;
                    r_emit_idx   <= '0;
                end
                ST_SCAN_T, ST_DRAIN_T: begin
                    r_addr <= (r_state == ST_SCAN_T) ? r_addr + 1'b1 : '0;
                    if (scan_hit) begin
                        r_best_cnt <= scan_data;
                        r_top_ttl  <= r_scan_a[TTL_AW-1:0];
                    end
                end
                ST_SCAN_W, ST_DRAIN_W: begin
                    if (r_state == ST_SCAN_W) r_addr <= r_addr + 1'b1;
                    if (!r_scan_v) r_best_cnt <= '0;
                    else if (scan_hit) begin
                        r_best_cnt <= scan_data;
                        r_top_win  <= r_scan_a;
                    end
                end
                ST_PROF: begin
                    r_pidx <= r_pidx + 1'b1;
                    if (score > r_top_score) begin
                        r_top_score <= score;
                        r_best_prof <= 4'({1'b0, r_pidx} + 5'd1);
                    end
                end
                ST_EMIT: if (emit_load) r_emit_idx <= r_emit_idx + 4'd1;
                default: r_addr <= r_addr;
            endcase
        end
    end

    // Output register
    logic [31:0] emit_val;
    always_comb begin
        case (r_emit_idx)
            IDX_TTL:     emit_val = {{(32-TTL_AW){1'b0}}, r_top_ttl};
            IDX_WINDOW:  emit_val = {{(32-WIN_AW){1'b0}}, r_top_win};
            IDX_PROFILE: emit_val = {28'd0, r_best_prof};
            IDX_SCORE:   emit_val = {24'd0, r_top_score};
            default:     emit_val = (r_emit_idx < IDX_TTL) ? r_cnt[r_emit_idx][31:0] : 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (emit_load) begin
            r_out_idx  <= r_emit_idx;
            r_out_val  <= emit_val;
            r_out_last <= (r_emit_idx == IDX_SCORE);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_val, r_out_idx};
    assign m_axis_tlast  = r_out_last;

endmodule

// File: hw/rtl/psof_checker.sv
// Port-level checks for the packet statistics and OS fingerprint block,
// bound to the top level. Depends on psof_pkg.
`timescale 1ns / 1ps

module psof_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    import psof_pkg::*;

    // The final beat of a report always carries the score.
    a_last_is_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[3:0] == IDX_SCORE)
        else $error("report closed on a beat other than the score");

    // Report beats follow one another in index order without gaps.
    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
        m_axis_tvalid && m_axis_tdata[3:0] == $past(m_axis_tdata[3:0]) + 4'd1)
        else $error("report beat index skipped");

    // No slave beat is taken while a report beat other than the final one is valid.
    a_busy_in_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input accepted during a report");

    // A stalled master beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled beat changed");

endmodule

bind packet_stats_os_fingerprint psof_checker u_psof_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
